@@ rtl/bpec_pkg.sv @@
// Shared types and constants for the ball pair elastic collision block.
// No dependencies.
package bpec_pkg;

  localparam int unsigned VW     = 16;  // velocity / position width
  localparam int unsigned DW     = 17;  // difference width
  localparam int unsigned DSQW   = 33;  // |d|^2 width
  localparam int unsigned DOTW   = 34;  // signed d.rv width
  localparam int unsigned NUMW   = 51;  // dividend width
  localparam int unsigned QW     = 18;  // quotient width
  localparam int unsigned CDW    = 15;  // contact distance width

  localparam logic [CDW-1:0] CONTACT_RESET = 15'd512;  // 2.0 in Q7.8

  // payload that rides along the divider stages
  typedef struct packed {
    logic signed [VW-1:0]   avx;
    logic signed [VW-1:0]   avy;
    logic signed [VW-1:0]   bvx;
    logic signed [VW-1:0]   bvy;
    logic                   hit;
    logic                   sgnx;
    logic                   sgny;
    logic [DSQW-1:0]        den;
  } carry_t;

endpackage

@@ rtl/ball_pair_elastic_collision_top.sv @@
// Top level of the ball pair elastic collision block: a 25-stage pipeline.
// Depends on bpec_pkg.
//
// One disc pair enters per clock unless the output stalls, and the sustained rate is
// one pair per cycle while m_tready holds. Stages: 1 differences, 2 products,
// 3 |d|^2 and d.rv, 4 collision test and magnitudes, 5 partial products of
// d*(d.rv), 6 dividend with rounding bias, 7-24 one quotient bit per stage of
// a restoring divider (one for x, one for y), 25 sign, add and saturate into
// the output register. The whole pipe advances together whenever the output
// register is empty or being taken, so a stall holds every request in place.
// The user must write contact_distance via cfg_we/cfg_wdata only while the block is idle (not enforced).
module ball_pair_elastic_collision_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // a_x, a_y, a_vx, a_vy, b_x, b_y, b_vx, b_vy
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // a_vx_new, a_vy_new, b_vx_new, b_vy_new
  output logic         m_tuser    // collided
);

  localparam int unsigned NS = bpec_pkg::QW;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // configuration
  logic [bpec_pkg::CDW-1:0]   contact_distance;
  logic [2*bpec_pkg::CDW-1:0] csq;
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_distance <= bpec_pkg::CONTACT_RESET;
    end else if (cfg_we) begin
      contact_distance <= cfg_wdata;
    end
    csq <= contact_distance * contact_distance;
  end

  // input fields
  logic signed [15:0] a_x, a_y, a_vx, a_vy, b_x, b_y, b_vx, b_vy;
  assign a_x  = s_tdata[15:0];
  assign a_y  = s_tdata[31:16];
  assign a_vx = s_tdata[47:32];
  assign a_vy = s_tdata[63:48];
  assign b_x  = s_tdata[79:64];
  assign b_y  = s_tdata[95:80];
  assign b_vx = s_tdata[111:96];
  assign b_vy = s_tdata[127:112];

  logic v1, v2, v3, v4, v5, v6;

  // stage 1: differences
  logic signed [16:0] dx1, dy1, rvx1, rvy1;
  logic signed [15:0] avx1, avy1, bvx1, bvy1;
  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= {b_x[15], b_x} - {a_x[15], a_x};
      dy1  <= {b_y[15], b_y} - {a_y[15], a_y};
      rvx1 <= {b_vx[15], b_vx} - {a_vx[15], a_vx};
      rvy1 <= {b_vy[15], b_vy} - {a_vy[15], a_vy};
      avx1 <= a_vx; avy1 <= a_vy; bvx1 <= b_vx; bvy1 <= b_vy;
    end
  end

  // stage 2: products
  logic signed [33:0] dxx2, dyy2, pxr2, pyr2;
  logic signed [16:0] dx2, dy2;
  logic signed [15:0] avx2, avy2, bvx2, bvy2;
  always_ff @(posedge clk) begin
    if (en) begin
      dxx2 <= dx1 * dx1;
      dyy2 <= dy1 * dy1;
      pxr2 <= dx1 * rvx1;
      pyr2 <= dy1 * rvy1;
      dx2 <= dx1; dy2 <= dy1;
      avx2 <= avx1; avy2 <= avy1; bvx2 <= bvx1; bvy2 <= bvy1;
    end
  end

  // stage 3: |d|^2 and d.rv
  logic [bpec_pkg::DSQW-1:0]        dsq3;
  logic signed [bpec_pkg::DOTW-1:0] dot3;
  logic signed [16:0] dx3, dy3;
  logic signed [15:0] avx3, avy3, bvx3, bvy3;
  logic [33:0] dsq_sum;
  assign dsq_sum = dxx2 + dyy2;
  always_ff @(posedge clk) begin
    if (en) begin
      dsq3 <= dsq_sum[bpec_pkg::DSQW-1:0];
      dot3 <= pxr2 + pyr2;
      dx3 <= dx2; dy3 <= dy2;
      avx3 <= avx2; avy3 <= avy2; bvx3 <= bvx2; bvy3 <= bvy2;
    end
  end

  // stage 4: collision test and magnitudes
  logic               hit4, sgnx4, sgny4;
  logic [32:0]        dotm4;
  logic [16:0]        dxm4, dym4;
  logic [bpec_pkg::DSQW-1:0] dsq4;
  logic signed [15:0] avx4, avy4, bvx4, bvy4;
  logic [33:0] dot_neg;
  logic [16:0] dx_neg, dy_neg;
  assign dot_neg = -dot3;
  assign dx_neg  = -dx3;
  assign dy_neg  = -dy3;
  always_ff @(posedge clk) begin
    if (en) begin
      hit4  <= (dsq3 < {3'b0, csq}) && dot3[33] && (dsq3 != '0);
      dotm4 <= dot3[33] ? dot_neg[32:0] : dot3[32:0];
      dxm4  <= dx3[16] ? dx_neg : dx3;
      dym4  <= dy3[16] ? dy_neg : dy3;
      sgnx4 <= dx3[16] ^ dot3[33];
      sgny4 <= dy3[16] ^ dot3[33];
      dsq4  <= dsq3;
      avx4 <= avx3; avy4 <= avy3; bvx4 <= bvx3; bvy4 <= bvy3;
    end
  end

  // stage 5: partial products of |d| * |d.rv|
  logic [33:0] xlo5, xhi5, ylo5, yhi5;
  bpec_pkg::carry_t c5;
  always_ff @(posedge clk) begin
    if (en) begin
      xlo5 <= dxm4 * dotm4[16:0];
      xhi5 <= dxm4 * {1'b0, dotm4[32:17]};
      ylo5 <= dym4 * dotm4[16:0];
      yhi5 <= dym4 * {1'b0, dotm4[32:17]};
      c5   <= '{avx: avx4, avy: avy4, bvx: bvx4, bvy: bvy4, hit: hit4,
                sgnx: sgnx4, sgny: sgny4, den: dsq4};
    end
  end

  // stage 6: dividend plus half the divisor (round half away from zero)
  logic [bpec_pkg::NUMW-1:0] numx6, numy6;
  bpec_pkg::carry_t c6;
  always_ff @(posedge clk) begin
    if (en) begin
      numx6 <= {17'b0, xlo5} + {xhi5[33:0], 17'b0}
               + {19'b0, c5.den[bpec_pkg::DSQW-1:1]};
      numy6 <= {17'b0, ylo5} + {yhi5[33:0], 17'b0}
               + {19'b0, c5.den[bpec_pkg::DSQW-1:1]};
      c6 <= c5;
    end
  end

  // stages 7-24: restoring division, quotient MSB first
  logic [bpec_pkg::NUMW-1:0] remx [0:NS];
  logic [bpec_pkg::NUMW-1:0] remy [0:NS];
  logic [bpec_pkg::QW-1:0]   qx   [0:NS];
  logic [bpec_pkg::QW-1:0]   qy   [0:NS];
  bpec_pkg::carry_t          dc   [0:NS];
  logic                      dv   [0:NS];

  assign remx[0] = numx6;
  assign remy[0] = numy6;
  assign qx[0]   = '0;
  assign qy[0]   = '0;
  assign dc[0]   = c6;
  assign dv[0]   = v6;

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int unsigned BIT = NS - 1 - k;
    logic [bpec_pkg::NUMW-1:0] sh;
    logic gex, gey;
    assign sh  = {{(bpec_pkg::NUMW - bpec_pkg::DSQW){1'b0}}, dc[k].den} << BIT;
    assign gex = remx[k] >= sh;
    assign gey = remy[k] >= sh;
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
      if (en) begin
        remx[k+1] <= gex ? remx[k] - sh : remx[k];
        remy[k+1] <= gey ? remy[k] - sh : remy[k];
        qx[k+1]   <= qx[k] | ({{(bpec_pkg::QW-1){1'b0}}, gex} << BIT);
        qy[k+1]   <= qy[k] | ({{(bpec_pkg::QW-1){1'b0}}, gey} << BIT);
        dc[k+1]   <= dc[k];
      end
    end
  end

  // stage 25: apply the exchange and saturate
  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      sat16 = 16'h7fff;
    end else if (v < -19'sd32768) begin
      sat16 = 16'h8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  bpec_pkg::carry_t   cf;
  logic signed [18:0] ddx, ddy, sax, say, sbx, sby;
  assign cf  = dc[NS];
  assign ddx = cf.sgnx ? -$signed({1'b0, qx[NS]}) : $signed({1'b0, qx[NS]});
  assign ddy = cf.sgny ? -$signed({1'b0, qy[NS]}) : $signed({1'b0, qy[NS]});
  assign sax = $signed({{3{cf.avx[15]}}, cf.avx}) + ddx;
  assign say = $signed({{3{cf.avy[15]}}, cf.avy}) + ddy;
  assign sbx = $signed({{3{cf.bvx[15]}}, cf.bvx}) - ddx;
  assign sby = $signed({{3{cf.bvy[15]}}, cf.bvy}) - ddy;

  always_ff @(posedge clk) begin
    if (en) begin
      if (cf.hit) begin
        m_tdata <= {sat16(sby), sat16(sbx), sat16(say), sat16(sax)};
      end else begin
        m_tdata <= {cf.bvy, cf.bvx, cf.avy, cf.avx};
      end
      m_tuser <= cf.hit;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      m_tvalid <= dv[NS];
    end
  end

  // quotient never exceeds |rv| (plus rounding) on a real collision
  a_qx_bound: assert property (@(posedge clk) disable iff (rst)
    dv[NS] && cf.hit |-> qx[NS] <= 18'd131072)
    else $error("x quotient out of range");
  a_qy_bound: assert property (@(posedge clk) disable iff (rst)
    dv[NS] && cf.hit |-> qy[NS] <= 18'd131072)
    else $error("y quotient out of range");
  // a request at the test stage reaches the partial product stage
  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && v4 |=> v5)
    else $error("request lost between stages");
  // a hit never has coincident centers
  a_hit_den: assert property (@(posedge clk) disable iff (rst)
    dv[NS] && cf.hit |-> cf.den != '0)
    else $error("collision with zero distance");

endmodule

@@ bench/ball_pair_elastic_collision_top_test.sv @@
// Self-checking bench for ball_pair_elastic_collision_top: random and directed disc pairs,
// predicted velocities compared against the stream output. Depends on bpec_pkg and the block.
module ball_pair_elastic_collision_top_test;

  typedef struct {
    logic signed [15:0] ax, ay, avx, avy, bx, by, bvx, bvy;
  } pair_t;

  typedef struct {
    logic [15:0] avx, avy, bvx, bvy;
    logic        hit;
  } bounce_t;

  // stimulus entry: a pair, or a register write once the pipe is empty
  typedef struct {
    logic        is_cfg;
    logic [14:0] cd;
    pair_t       p;
  } req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [14:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  req_t    pending_q[$];
  bounce_t bounce_q[$];
  logic [14:0] contact_dist = bpec_pkg::CONTACT_RESET;
  int errors = 0;
  int src_gap = 0, sink_gap = 0;
  bit stim_done = 0;

  ball_pair_elastic_collision_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned_div_round(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // exact collision response along the center line
  function automatic bounce_t predict_bounce(pair_t p, logic [14:0] cd);
    longint dx, dy, rvx, rvy, dsq, csq, dot, ddx, ddy;
    bounce_t r;
    dx = longint'(p.bx) - longint'(p.ax);
    dy = longint'(p.by) - longint'(p.ay);
    rvx = longint'(p.bvx) - longint'(p.avx);
    rvy = longint'(p.bvy) - longint'(p.avy);
    dsq = dx * dx + dy * dy;
    csq = longint'(cd) * longint'(cd);
    dot = dx * rvx + dy * rvy;
    r.hit = (dsq < csq) && (dot < 0) && (dsq != 0);
    r.avx = p.avx; r.avy = p.avy; r.bvx = p.bvx; r.bvy = p.bvy;
    if (r.hit) begin
      ddx = unsigned_div_round(dx * dot, dsq);
      ddy = unsigned_div_round(dy * dot, dsq);
      r.avx = 16'(clamp16(p.avx + ddx));
      r.avy = 16'(clamp16(p.avy + ddy));
      r.bvx = 16'(clamp16(p.bvx - ddx));
      r.bvy = 16'(clamp16(p.bvy - ddy));
    end
    return r;
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    p.ax = rnd16(); p.ay = rnd16();
    p.avx = rnd16(); p.avy = rnd16();
    p.bvx = rnd16(); p.bvy = rnd16();
    case ($urandom_range(0, 3))
      0: begin
        p.bx = rnd16(); p.by = rnd16();
      end
      default: begin
        // near neighbors, so most pairs are within contact range
        span = 1 << $urandom_range(2, 10);
        p.bx = p.ax + 16'($urandom_range(0, 2 * span) - span);
        p.by = p.ay + 16'($urandom_range(0, 2 * span) - span);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      // modest velocities keep the exchange out of saturation
      p.avx = p.avx >>> 6; p.avy = p.avy >>> 6;
      p.bvx = p.bvx >>> 6; p.bvy = p.bvy >>> 6;
    end
    return p;
  endfunction

  task automatic add_pair(logic signed [15:0] ax, ay, avx, avy, bx, by, bvx, bvy);
    req_t r;
    r.is_cfg = 0; r.cd = '0;
    r.p.ax = ax; r.p.ay = ay; r.p.avx = avx; r.p.avy = avy;
    r.p.bx = bx; r.p.by = by; r.p.bvx = bvx; r.p.bvy = bvy;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic add_cfg(logic [14:0] cd);
    req_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.cd = cd;
    pending_q.insert(pending_q.size(), r);
  endtask

  // driver: register writes wait until every expected result has been received
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      cfg_we <= 1'b0;
      if (s_tvalid && s_tready) begin
        bounce_q.insert(bounce_q.size(), predict_bounce(pending_q[0].p, contact_dist));
        void'(pending_q.pop_front());
        src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          s_tvalid <= 1'b0;
          stim_done = 1;
        end else if (pending_q[0].is_cfg) begin
          s_tvalid <= 1'b0;
          if (bounce_q.size() == 0 && !(s_tvalid && s_tready)) begin
            cfg_we <= 1'b1;
            cfg_wdata <= pending_q[0].cd;
            contact_dist = pending_q[0].cd;
            void'(pending_q.pop_front());
            src_gap = 30;
          end
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= {pending_q[0].p.bvy, pending_q[0].p.bvx, pending_q[0].p.by,
                      pending_q[0].p.bx, pending_q[0].p.avy, pending_q[0].p.avx,
                      pending_q[0].p.ay, pending_q[0].p.ax};
        end
      end
    end
  end

  // monitor: random back-pressure and field-by-field checking
  always @(posedge clk) begin
    bounce_t exp_b;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bounce_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h hit %b", m_tdata, m_tuser);
        end else begin
          exp_b = bounce_q.pop_front();
          if (m_tdata !== {exp_b.bvy, exp_b.bvx, exp_b.avy, exp_b.avx} ||
              m_tuser !== exp_b.hit) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %h %h %h %h hit %b, got %h %h %h %h hit %b",
                       exp_b.avx, exp_b.avy, exp_b.bvx, exp_b.bvy, exp_b.hit,
                       m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                       m_tuser);
          end
        end
        sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: head-on touch, coincident centers, receding, extremes
    add_pair(0, 0, 16'sd256, 0, 16'sd256, 0, -16'sd256, 0);
    add_pair(0, 0, 16'sd256, 0, 0, 0, -16'sd256, 0);
    add_pair(0, 0, -16'sd256, 0, 16'sd256, 0, 16'sd256, 0);
    add_pair(0, 0, 16'sh7fff, 16'sh7fff, 16'sd100, 16'sd100, 16'sh8000, 16'sh8000);
    add_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh8000);
    add_pair(16'sd10, 16'sd20, 16'sd5, -16'sd7, 16'sd11, 16'sd19, -16'sd3, 16'sd9);
    add_pair(0, 0, 16'sd1, 16'sd1, 16'sd512, 0, 0, 0);
    add_pair(0, 0, 16'sd1, 0, 16'sd511, 0, 0, 0);
    add_pair(0, 0, 16'sd3, 16'sd3, 16'sd3, 16'sd4, 16'sd0, 16'sd0);
    add_pair(16'sh7fff, 0, 0, 0, 16'sh8000, 0, 0, 0);
    add_cfg(15'd0);
    add_pair(0, 0, 16'sd256, 0, 16'sd1, 0, -16'sd256, 0);
    add_cfg(15'h7fff);
    add_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
             16'sh8000, 16'sh8000);
    add_pair(0, 0, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000, 16'sh7fff);
    for (k = 0; k < 6; k++) begin
      add_cfg(k == 0 ? bpec_pkg::CONTACT_RESET
                     : (k == 5 ? 15'h7fff : 15'($urandom_range(1, 4096))));
      repeat (155)
        pending_q.insert(pending_q.size(), req_t'{is_cfg: 0, cd: '0, p: rand_pair()});
    end
    wait (stim_done && bounce_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("** ball_pair_elastic_collision_top: PASSED **");
    end else begin
      $display("** ball_pair_elastic_collision_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** ball_pair_elastic_collision_top: FAILED **");
    $finish;
  end
endmodule
